@@ hdl/env_sensor_compensation_unit_defines.svh @@
// Assertion macros for the compensation unit RTL.
`ifndef ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_UNIT_DEFINES_SVH

// Implication checked in the same cycle.
`define ESC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define ESC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/esc_pkg.sv @@
// Types, constants and helpers of the sensor compensation unit.
package esc_pkg;

    localparam int unsigned DIV_STEPS = 32;

    localparam logic [2:0] REG_TEMP    = 3'd0;
    localparam logic [2:0] REG_PRESS_A = 3'd1;
    localparam logic [2:0] REG_PRESS_B = 3'd2;
    localparam logic [2:0] REG_PRESS_9 = 3'd3;
    localparam logic [2:0] REG_HUM     = 3'd4;

    localparam logic [31:0] HUM_MAX  = 32'd419430400;
    localparam logic [16:0] HUM_Q10_MAX = 17'd102400;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
        logic [15:0] raw_hum;
    } in_t;

    typedef struct packed {
        logic signed [31:0] temp_centi;
        logic [31:0]        press_pa;
        logic [16:0]        hum_q10;
    } out_t;

    // Coefficients, extended to 32-bit words.
    typedef struct packed {
        logic [31:0] t1, t2, t3;
        logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [31:0] h1, h2, h3, h4, h5, h6;
    } coef_t;

    // Values that ride alongside the divider.
    typedef struct packed {
        logic [31:0] temp;
        logic [31:0] hb;
        logic [31:0] hd;
        logic        halved;
        logic        zero;
    } side_t;

    function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
        return $unsigned($signed(x) >>> n);
    endfunction

endpackage

@@ hdl/esc_front.sv @@
// Temperature and pressure/humidity preparation stages ahead of the divider.
module esc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  esc_pkg::in_t      in_data,
    input  esc_pkg::coef_t    coef,
    output logic              out_valid,
    output logic [31:0]       out_dividend,
    output logic [31:0]       out_divisor,
    output esc_pkg::side_t    out_side
);
    logic [11:1] v_reg;
    logic [31:0] s1_ta_reg, s1_td_reg;
    logic [19:0] p_reg [1:9];
    logic [15:0] h_reg [1:6];
    logic [31:0] s2_ma_reg, s2_dd_reg;
    logic [31:0] s3_at_reg, s3_x_reg;
    logic [31:0] s4_fine_reg;
    logic [31:0] s5_tm_reg, s5_pa_reg, s5_ha_reg;
    logic [31:0] temp_reg [6:11];
    logic [31:0] s6_pdd_reg, s6_pa5_reg, s6_pa2_reg, s6_h5a_reg, s6_ah6_reg, s6_ah3_reg;
    logic [31:0] s7_b1_reg, s7_c1_reg, s7_hb0_reg, s7_m6_reg, s7_m3_reg;
    logic [31:0] s7_pa5_reg, s7_pa2_reg;
    logic [31:0] s8_b2_reg, s8_pa_reg, s8_hm_reg;
    logic [31:0] hb_reg [8:11];
    logic [31:0] s9_pb_reg, s9_pq_reg, s9_hd1_reg;
    logic [31:0] s10_pdiv_reg, s10_pnum_reg, s10_hd2_reg;
    logic [31:0] s11_dvd_reg, s11_dvs_reg, s11_hd_reg;
    logic        s11_halved_reg, s11_zero_reg;
    logic [31:0] pd_w, rt_w;

    assign rt_w = {12'b0, in_data.raw_temp};
    assign pd_w = esc_pkg::asr(s5_pa_reg, 5'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[10:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // temperature
            s1_ta_reg <= (rt_w >> 3) - (coef.t1 << 1);
            s1_td_reg <= (rt_w >> 4) - coef.t1;
            p_reg[1]  <= in_data.raw_press;
            h_reg[1]  <= in_data.raw_hum;
            for (int i = 2; i <= 9; i++) p_reg[i] <= p_reg[i-1];
            for (int i = 2; i <= 6; i++) h_reg[i] <= h_reg[i-1];
            s2_ma_reg <= s1_ta_reg * coef.t2;
            s2_dd_reg <= s1_td_reg * s1_td_reg;
            s3_at_reg <= esc_pkg::asr(s2_ma_reg, 5'd11);
            s3_x_reg  <= esc_pkg::asr(s2_dd_reg, 5'd12) * coef.t3;
            s4_fine_reg <= s3_at_reg + esc_pkg::asr(s3_x_reg, 5'd14);
            s5_tm_reg <= s4_fine_reg * 32'd5;
            s5_pa_reg <= esc_pkg::asr(s4_fine_reg, 5'd1) - 32'd64000;
            s5_ha_reg <= s4_fine_reg - 32'd76800;
            // fan out products of the fine temperature terms
            temp_reg[6] <= esc_pkg::asr(s5_tm_reg + 32'd128, 5'd8);
            for (int i = 7; i <= 11; i++) temp_reg[i] <= temp_reg[i-1];
            s6_pdd_reg <= pd_w * pd_w;
            s6_pa5_reg <= s5_pa_reg * coef.p5;
            s6_pa2_reg <= coef.p2 * s5_pa_reg;
            s6_h5a_reg <= coef.h5 * s5_ha_reg;
            s6_ah6_reg <= s5_ha_reg * coef.h6;
            s6_ah3_reg <= s5_ha_reg * coef.h3;
            s7_b1_reg  <= esc_pkg::asr(s6_pdd_reg, 5'd11) * coef.p6;
            s7_c1_reg  <= coef.p3 * esc_pkg::asr(s6_pdd_reg, 5'd13);
            s7_hb0_reg <= ({16'b0, h_reg[6]} << 14) - (coef.h4 << 20) - s6_h5a_reg
                          + 32'd16384;
            s7_m6_reg  <= esc_pkg::asr(s6_ah6_reg, 5'd10);
            s7_m3_reg  <= esc_pkg::asr(s6_ah3_reg, 5'd11) + 32'd32768;
            s7_pa5_reg <= s6_pa5_reg;
            s7_pa2_reg <= s6_pa2_reg;
            s8_b2_reg  <= s7_b1_reg + (s7_pa5_reg << 1);
            s8_pa_reg  <= esc_pkg::asr(esc_pkg::asr(s7_c1_reg, 5'd3)
                          + esc_pkg::asr(s7_pa2_reg, 5'd1), 5'd18);
            hb_reg[8]  <= esc_pkg::asr(s7_hb0_reg, 5'd15);
            for (int i = 9; i <= 11; i++) hb_reg[i] <= hb_reg[i-1];
            s8_hm_reg  <= s7_m6_reg * s7_m3_reg;
            s9_pb_reg  <= esc_pkg::asr(s8_b2_reg, 5'd2) + (coef.p4 << 16);
            s9_pq_reg  <= (32'd32768 + s8_pa_reg) * coef.p1;
            s9_hd1_reg <= esc_pkg::asr(s8_hm_reg, 5'd10) + 32'd2097152;
            s10_pdiv_reg <= esc_pkg::asr(s9_pq_reg, 5'd15);
            s10_pnum_reg <= ((32'd1048576 - {12'b0, p_reg[9]})
                            - esc_pkg::asr(s9_pb_reg, 5'd12)) * 32'd3125;
            s10_hd2_reg  <= s9_hd1_reg * coef.h2 + 32'd8192;
            // pick the division form by the numerator's top bit
            s11_halved_reg <= s10_pnum_reg[31];
            s11_dvd_reg    <= s10_pnum_reg[31] ? s10_pnum_reg : (s10_pnum_reg << 1);
            s11_dvs_reg    <= s10_pdiv_reg;
            s11_zero_reg   <= (s10_pdiv_reg == '0);
            s11_hd_reg     <= esc_pkg::asr(s10_hd2_reg, 5'd14);
        end
    end

    assign out_valid       = v_reg[11];
    assign out_dividend    = s11_dvd_reg;
    assign out_divisor     = s11_dvs_reg;
    assign out_side.temp   = temp_reg[11];
    assign out_side.hb     = hb_reg[11];
    assign out_side.hd     = s11_hd_reg;
    assign out_side.halved = s11_halved_reg;
    assign out_side.zero   = s11_zero_reg;
endmodule

@@ hdl/esc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
module esc_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       in_dividend,
    input  logic [31:0]       in_divisor,
    input  esc_pkg::side_t    in_side,
    output logic              out_valid,
    output logic [31:0]       out_quot,
    output esc_pkg::side_t    out_side
);
    localparam int unsigned N = esc_pkg::DIV_STEPS;

    logic           v_reg    [N];
    logic [31:0]    rem_reg  [N];
    logic [31:0]    q_reg    [N];
    logic [31:0]    d_reg    [N];
    esc_pkg::side_t side_reg [N];

    for (genvar i = 0; i < N; i++) begin : g_step
        logic           pv;
        logic [31:0]    prem, pq, pd;
        esc_pkg::side_t ps;
        logic [32:0]    trial, diff;
        if (i == 0) begin : g_first
            assign pv = in_valid;
            assign prem = '0;
            assign pq = in_dividend;
            assign pd = in_divisor;
            assign ps = in_side;
        end else begin : g_rest
            assign pv = v_reg[i-1];
            assign prem = rem_reg[i-1];
            assign pq = q_reg[i-1];
            assign pd = d_reg[i-1];
            assign ps = side_reg[i-1];
        end
        assign trial = {prem, pq[31]};
        assign diff  = trial - {1'b0, pd};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= diff[32] ? trial[31:0] : diff[31:0];
                q_reg[i]    <= {pq[30:0], ~diff[32]};
                d_reg[i]    <= pd;
                side_reg[i] <= ps;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quot  = q_reg[N-1];
    assign out_side  = side_reg[N-1];
endmodule

@@ hdl/esc_back.sv @@
// Pressure correction and humidity stages after the divider; holds the output register.
module esc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [31:0]       in_quot,
    input  esc_pkg::side_t    in_side,
    input  esc_pkg::coef_t    coef,
    output logic              out_valid,
    output esc_pkg::out_t     out_data
);
    logic [5:1]  v_reg;
    logic [31:0] temp_reg [1:4];
    logic        zero_reg [1:3];
    logic [31:0] b1_pr_reg, b1_hm_reg;
    logic [31:0] b2_dd_reg, b2_s8_reg, b2_hb2_reg, b2_pr_reg, b2_hm_reg;
    logic [31:0] b3_a9_reg, b3_bb_reg, b3_hbb_reg, b3_pr_reg, b3_hm_reg;
    logic [31:0] b4_pr_reg, b4_hx_reg, b4_hm_reg;
    esc_pkg::out_t out_reg;
    logic [31:0] hv_w, hc_w, d_w;

    assign d_w  = b1_pr_reg >> 3;
    assign hv_w = b4_hm_reg - esc_pkg::asr(b4_hx_reg, 5'd4);
    assign hc_w = hv_w[31] ? 32'd0 : ((hv_w > esc_pkg::HUM_MAX) ? esc_pkg::HUM_MAX : hv_w);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg[1] <= in_side.temp;
            zero_reg[1] <= in_side.zero;
            for (int i = 2; i <= 4; i++) temp_reg[i] <= temp_reg[i-1];
            for (int i = 2; i <= 3; i++) zero_reg[i] <= zero_reg[i-1];
            b1_pr_reg  <= in_side.halved ? (in_quot << 1) : in_quot;
            b1_hm_reg  <= in_side.hb * in_side.hd;
            b2_dd_reg  <= d_w * d_w;
            b2_s8_reg  <= (b1_pr_reg >> 2) * coef.p8;
            b2_hb2_reg <= esc_pkg::asr(b1_hm_reg, 5'd15);
            b2_pr_reg  <= b1_pr_reg;
            b2_hm_reg  <= b1_hm_reg;
            b3_a9_reg  <= coef.p9 * (b2_dd_reg >> 13);
            b3_bb_reg  <= esc_pkg::asr(b2_s8_reg, 5'd13);
            b3_hbb_reg <= b2_hb2_reg * b2_hb2_reg;
            b3_pr_reg  <= b2_pr_reg;
            b3_hm_reg  <= b2_hm_reg;
            // drop the pressure to zero when the divisor was zero
            b4_pr_reg  <= zero_reg[3] ? 32'd0 : b3_pr_reg + esc_pkg::asr(
                          esc_pkg::asr(b3_a9_reg, 5'd12) + b3_bb_reg + coef.p7, 5'd4);
            b4_hx_reg  <= esc_pkg::asr(b3_hbb_reg, 5'd7) * coef.h1;
            b4_hm_reg  <= b3_hm_reg;
            out_reg.temp_centi <= $signed(temp_reg[4]);
            out_reg.press_pa   <= b4_pr_reg;
            out_reg.hum_q10    <= hc_w[28:12];
        end
    end

    assign out_valid = v_reg[5];
    assign out_data  = out_reg;
endmodule

@@ hdl/env_sensor_compensation_unit.sv @@
// Pipeline: 11 front, 32 divider and 5 back stages from input transfer to result.
// Throughput: one burst per cycle unless stalled; the 32-stage bit-per-stage divider sets the depth.
// A stall at the result port freezes every stage at once; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all stage valid bits and every coefficient.
// Configuration writes are always accepted; an index above four is ignored.
`include "env_sensor_compensation_unit_defines.svh"
module env_sensor_compensation_unit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  esc_pkg::in_t    s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output esc_pkg::out_t   m_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data
);
    // Calibration registers, as written.
    logic [47:0] temp_coeffs_reg;
    logic [63:0] press_a_reg, press_b_reg, hum_coeffs_reg;
    logic [15:0] press_nine_reg;

    esc_pkg::coef_t coef;
    logic           en;
    logic           f_valid, d_valid;
    logic [31:0]    f_dvd, f_dvs, d_quot;
    esc_pkg::side_t f_side, d_side;

    // Whole pipeline advances unless a finished result is waiting.
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_a_reg     <= '0;
            press_b_reg     <= '0;
            press_nine_reg  <= '0;
            hum_coeffs_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                esc_pkg::REG_TEMP:    temp_coeffs_reg <= cfg_data[47:0];
                esc_pkg::REG_PRESS_A: press_a_reg     <= cfg_data;
                esc_pkg::REG_PRESS_B: press_b_reg     <= cfg_data;
                esc_pkg::REG_PRESS_9: press_nine_reg  <= cfg_data[15:0];
                esc_pkg::REG_HUM:     hum_coeffs_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack every coefficient to a 32-bit word; t1, p1 and h1 are zero-extended, the rest sign-extended.
    always_comb begin
        coef.t1 = {16'b0, temp_coeffs_reg[15:0]};
        coef.t2 = {{16{temp_coeffs_reg[31]}}, temp_coeffs_reg[31:16]};
        coef.t3 = {{16{temp_coeffs_reg[47]}}, temp_coeffs_reg[47:32]};
        coef.p1 = {16'b0, press_a_reg[15:0]};
        coef.p2 = {{16{press_a_reg[31]}}, press_a_reg[31:16]};
        coef.p3 = {{16{press_a_reg[47]}}, press_a_reg[47:32]};
        coef.p4 = {{16{press_a_reg[63]}}, press_a_reg[63:48]};
        coef.p5 = {{16{press_b_reg[15]}}, press_b_reg[15:0]};
        coef.p6 = {{16{press_b_reg[31]}}, press_b_reg[31:16]};
        coef.p7 = {{16{press_b_reg[47]}}, press_b_reg[47:32]};
        coef.p8 = {{16{press_b_reg[63]}}, press_b_reg[63:48]};
        coef.p9 = {{16{press_nine_reg[15]}}, press_nine_reg};
        coef.h1 = {24'b0, hum_coeffs_reg[7:0]};
        coef.h2 = {{16{hum_coeffs_reg[23]}}, hum_coeffs_reg[23:8]};
        coef.h3 = {{24{hum_coeffs_reg[31]}}, hum_coeffs_reg[31:24]};
        coef.h4 = {{20{hum_coeffs_reg[43]}}, hum_coeffs_reg[43:32]};
        coef.h5 = {{20{hum_coeffs_reg[55]}}, hum_coeffs_reg[55:44]};
        coef.h6 = {{24{hum_coeffs_reg[63]}}, hum_coeffs_reg[63:56]};
    end

    esc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .in_data      (s_data),
        .coef         (coef),
        .out_valid    (f_valid),
        .out_dividend (f_dvd),
        .out_divisor  (f_dvs),
        .out_side     (f_side)
    );

    esc_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (f_valid),
        .in_dividend (f_dvd),
        .in_divisor  (f_dvs),
        .in_side     (f_side),
        .out_valid   (d_valid),
        .out_quot    (d_quot),
        .out_side    (d_side)
    );

    esc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_quot   (d_quot),
        .in_side   (d_side),
        .coef      (coef),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

    // Humidity clamp must bound every delivered result.
    `ESC_ASSERT_NOW(a_hum_range, m_valid, m_data.hum_q10 <= esc_pkg::HUM_Q10_MAX, "humidity out of range")
    // A waiting result must hold off intake.
    `ESC_ASSERT_NOW(a_stall_intake, m_valid && !m_ready, !s_ready, "intake open during stall")
    // Writes beyond the register list leave calibration untouched.
    `ESC_ASSERT_NEXT(a_bad_index, cfg_valid && cfg_index > esc_pkg::REG_HUM, $stable(temp_coeffs_reg) && $stable(press_a_reg) && $stable(press_b_reg) && $stable(press_nine_reg) && $stable(hum_coeffs_reg), "bad index changed a register")
endmodule
